// ===== rtl/tlcd_pkg.sv =====
// ----------------------------------------------------------------------------
// tlcd_pkg
// shared types and constants of the teleop line command decoder
// ----------------------------------------------------------------------------
package tlcd_pkg;

	localparam int LINE_BYTES_DEF = 32;
	localparam int MQ_DEPTH_DEF   = 2;
	localparam int OQ_DEPTH_DEF   = 4;

	localparam int MAG_W = 32;
	localparam int SPD_W = 16;

	// drive operation decided by the command character
	localparam logic [2:0] OP_STOP  = 3'd0;
	localparam logic [2:0] OP_FWD   = 3'd1;
	localparam logic [2:0] OP_BACK  = 3'd2;
	localparam logic [2:0] OP_LEFT  = 3'd3;
	localparam logic [2:0] OP_RIGHT = 3'd4;

	typedef struct packed {
		logic [2:0]       op;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} line_cmd_t;

	typedef struct packed {
		logic signed [SPD_W-1:0] left;
		logic signed [SPD_W-1:0] right;
	} speed_pair_t;

endpackage

// ===== rtl/tlcd_fifo.sv =====
// ----------------------------------------------------------------------------
// tlcd_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module tlcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/tlcd_front.sv =====
// ----------------------------------------------------------------------------
// tlcd_front
// byte scanner: builds the command, sign and magnitude of one line
// ----------------------------------------------------------------------------
module tlcd_front import tlcd_pkg::*; #(
	parameter int LINE_BYTES = LINE_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  logic [7:0] rx_byte,
	output logic      cmd_push,
	output line_cmd_t cmd
);

	localparam int CNT_W = $clog2(LINE_BYTES);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(LINE_BYTES - 1);

	localparam logic [2:0] PH_CMD    = 3'd0;
	localparam logic [2:0] PH_SPACE  = 3'd1;
	localparam logic [2:0] PH_SIGN   = 3'd2;
	localparam logic [2:0] PH_DIGITS = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_VT    = 8'd11;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_B     = 8'd66;
	localparam logic [7:0] CH_F     = 8'd70;
	localparam logic [7:0] CH_L     = 8'd76;
	localparam logic [7:0] CH_R     = 8'd82;

	localparam logic [MAG_W+3:0] MAG_LIMIT = (MAG_W+4)'(33'h1_0000_0000 >> 1);

	logic [CNT_W-1:0] count_q, count_n;
	logic [7:0]       char_q, char_n;
	logic [2:0]       phase_q, phase_n;
	logic             neg_q, neg_n;
	logic [MAG_W-1:0] mag_q, mag_n;
	logic             ended_q, ended_n;

	logic             is_eol;
	logic             is_digit;
	logic             is_blank;
	logic [MAG_W+3:0] mag_acc;
	logic [MAG_W-1:0] mag_dig;

	assign is_eol   = (rx_byte == CH_LF) || (rx_byte == CH_CR);
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
	                  (rx_byte == CH_VT) || (rx_byte == CH_FF);

	// times ten plus digit, held at 2^31
	always_comb begin
		mag_acc = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) +
		          (MAG_W+4)'(rx_byte[3:0]);
		mag_dig = (mag_acc > MAG_LIMIT) ? MAG_LIMIT[MAG_W-1:0] : mag_acc[MAG_W-1:0];
	end

	always_comb begin
		count_n = count_q;
		char_n  = char_q;
		phase_n = phase_q;
		neg_n   = neg_q;
		mag_n   = mag_q;
		ended_n = ended_q;
		if ((is_eol && (count_q != '0)) || (!is_eol && (count_q >= LAST_CNT))) begin
			count_n = '0;
			char_n  = '0;
			phase_n = PH_CMD;
			neg_n   = 1'b0;
			mag_n   = '0;
			ended_n = 1'b0;
		end else if (!is_eol) begin
			count_n = count_q + 1'b1;
			if (!ended_q) begin
				if (rx_byte == CH_NUL) begin
					ended_n = 1'b1;
				end else begin
					case (phase_q)
						PH_CMD: begin
							char_n  = rx_byte;
							phase_n = PH_SPACE;
						end
						PH_SPACE: begin
							if (!is_blank) begin
								if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)) begin
									neg_n   = (rx_byte == CH_MINUS);
									phase_n = PH_SIGN;
								end else if (is_digit) begin
									mag_n   = mag_dig;
									phase_n = PH_DIGITS;
								end else begin
									phase_n = PH_DONE;
								end
							end
						end
						PH_SIGN, PH_DIGITS: begin
							if (is_digit) begin
								mag_n   = mag_dig;
								phase_n = PH_DIGITS;
							end else begin
								phase_n = PH_DONE;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			char_q  <= '0;
			phase_q <= PH_CMD;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			ended_q <= 1'b0;
		end else if (accept) begin
			count_q <= count_n;
			char_q  <= char_n;
			phase_q <= phase_n;
			neg_q   <= neg_n;
			mag_q   <= mag_n;
			ended_q <= ended_n;
		end
	end

	// a line with a command character gives a transaction to the back end
	assign cmd_push = accept && is_eol && (count_q != '0) && (phase_q != PH_CMD);

	always_comb begin
		case (char_q)
			CH_F:    cmd.op = OP_FWD;
			CH_B:    cmd.op = OP_BACK;
			CH_L:    cmd.op = OP_LEFT;
			CH_R:    cmd.op = OP_RIGHT;
			default: cmd.op = OP_STOP;
		endcase
		cmd.neg = neg_q;
		cmd.mag = mag_q;
	end

endmodule

// ===== rtl/tlcd_back.sv =====
// ----------------------------------------------------------------------------
// tlcd_back
// speed pipeline: signed value, scale by 130, divide by 500, sign per wheel
// ----------------------------------------------------------------------------
module tlcd_back import tlcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_pop,
	input  line_cmd_t   cmd,
	input  logic        res_full,
	output logic        res_push,
	output speed_pair_t res
);

	localparam logic signed [MAG_W-1:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [MAG_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [MAG_W+7:0] P_MAX = 40'sd2147483647;
	localparam logic signed [MAG_W+7:0] P_MIN = -40'sd2147483648;
	// floor(2^40 / 500), quotient estimate is exact or one low
	localparam logic [MAG_W-1:0] RECIP = 32'd2199023255;
	localparam int               RSHIFT = 40;
	localparam int               Q_W = 23;
	localparam logic [MAG_W-1:0] DIVISOR = 32'd500;

	function automatic logic signed [MAG_W-1:0] sat_neg(input logic signed [MAG_W-1:0] v);
		sat_neg = (v == S_MIN) ? S_MAX : -v;
	endfunction

	logic adv;
	assign adv     = !res_full;
	assign cmd_pop = cmd_valid && adv;

	// stage 1: signed number
	logic                    v_s1;
	logic [2:0]              op_s1;
	logic signed [MAG_W-1:0] s_s1;
	logic [MAG_W:0]          mag_neg;
	logic signed [MAG_W-1:0] s_val;

	always_comb begin
		mag_neg = -{1'b0, cmd.mag};
		if (cmd.neg) begin
			s_val = mag_neg[MAG_W-1:0];
		end else begin
			s_val = cmd.mag[MAG_W-1] ? S_MAX : cmd.mag;
		end
	end

	// stage 2: left speed and product by 130
	logic                    v_s2;
	logic [2:0]              op_s2;
	logic [SPD_W-1:0]        left_s2;
	logic signed [MAG_W-1:0] p_s2;
	logic signed [MAG_W+7:0] s_w;
	logic signed [MAG_W+7:0] prod130;
	logic signed [MAG_W-1:0] p_val;
	logic signed [MAG_W-1:0] left_val;

	always_comb begin
		s_w     = (MAG_W+8)'(s_s1);
		prod130 = (s_w <<< 7) + (s_w <<< 1);
		if (prod130 > P_MAX) begin
			p_val = S_MAX;
		end else if (prod130 < P_MIN) begin
			p_val = S_MIN;
		end else begin
			p_val = prod130[MAG_W-1:0];
		end
		case (op_s1)
			OP_FWD, OP_RIGHT: left_val = s_s1;
			OP_BACK, OP_LEFT: left_val = sat_neg(s_s1);
			default:          left_val = '0;
		endcase
	end

	// stage 3: right wheel numerator as sign and magnitude
	logic                    v_s3;
	logic [SPD_W-1:0]        left_s3;
	logic                    xneg_s3;
	logic [MAG_W-1:0]        a_s3;
	logic signed [MAG_W-1:0] x_val;

	always_comb begin
		case (op_s2)
			OP_FWD, OP_LEFT:  x_val = p_s2;
			OP_BACK, OP_RIGHT: x_val = sat_neg(p_s2);
			default:          x_val = '0;
		endcase
	end

	// stage 4: reciprocal multiply
	logic               v_s4;
	logic [SPD_W-1:0]   left_s4;
	logic               xneg_s4;
	logic [MAG_W-1:0]   a_s4;
	logic [Q_W-1:0]     q0_s4;
	logic [2*MAG_W-1:0] recip_prod;

	assign recip_prod = a_s3 * RECIP;

	// final step: one correction of the quotient estimate
	logic [MAG_W-1:0] rem;
	logic [Q_W-1:0]   quo;

	always_comb begin
		rem = a_s4 - (MAG_W'(q0_s4) * DIVISOR);
		quo = (rem >= DIVISOR) ? q0_s4 + 1'b1 : q0_s4;
		res.left  = left_s4;
		res.right = xneg_s4 ? -quo[SPD_W-1:0] : quo[SPD_W-1:0];
	end

	assign res_push = v_s4 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= cmd.op;
			s_s1    <= s_val;
			op_s2   <= op_s1;
			left_s2 <= left_val[SPD_W-1:0];
			p_s2    <= p_val;
			left_s3 <= left_s2;
			xneg_s3 <= x_val[MAG_W-1];
			a_s3    <= x_val[MAG_W-1] ? -x_val : x_val;
			left_s4 <= left_s3;
			xneg_s4 <= xneg_s3;
			a_s4    <= a_s3;
			q0_s4   <= recip_prod[RSHIFT+Q_W-1:RSHIFT];
		end
	end

endmodule

// ===== rtl/teleop_line_command_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// teleop_line_command_decoder_unit
// serial line command decoder giving left/right wheel speed pairs
// ----------------------------------------------------------------------------
// usage:
//   input side is a queue: drive rx_byte and push, a byte is taken when full
//   is low. one byte per cycle is taken back to back; byte 10 or 13 ends a
//   line and hands a command to the speed pipeline through a short queue.
//   result side is a queue: while empty is low the oldest speed pair is on
//   left_wheel/right_wheel, pop takes it.
//   from the line end byte to the pair showing, when the result queue has
//   room, a command passes the command queue, four pipeline registers
//   (signed value, scale by 130, magnitude, reciprocal multiply for /500)
//   and the result queue.
//   throughput is one byte per cycle while full is low; a line takes at least
//   two bytes, so the 32x32 reciprocal multiplier is never the limit.
//   when the receiver stalls the result queue fills, the pipeline holds,
//   then a line end fills the command queue and full rises; while it is
//   full every byte waits, otherwise bytes are scanned without waiting.
//   reset clears the scanner and both queues; full is low and empty high.
// ----------------------------------------------------------------------------
module teleop_line_command_decoder_unit import tlcd_pkg::*; #(
	parameter int LINE_BYTES = LINE_BYTES_DEF,
	parameter int MQ_DEPTH   = MQ_DEPTH_DEF,
	parameter int OQ_DEPTH   = OQ_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [7:0]              rx_byte,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [SPD_W-1:0] left_wheel,
	output logic signed [SPD_W-1:0] right_wheel
);

	logic        accept;
	logic        cmd_push;
	line_cmd_t   cmd_in;
	line_cmd_t   cmd_out;
	logic        mq_empty;
	logic        cmd_pop;
	logic        oq_full;
	logic        res_push;
	speed_pair_t res_in;
	speed_pair_t res_out;

	assign accept = push && !full;

	tlcd_front #(
		.LINE_BYTES(LINE_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.cmd_push(cmd_push),
		.cmd     (cmd_in)
	);

	tlcd_fifo #(
		.WIDTH($bits(line_cmd_t)),
		.DEPTH(MQ_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.full  (full),
		.wdata (cmd_in),
		.pop   (cmd_pop),
		.empty (mq_empty),
		.rdata (cmd_out)
	);

	tlcd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(!mq_empty),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd_out),
		.res_full (oq_full),
		.res_push (res_push),
		.res      (res_in)
	);

	tlcd_fifo #(
		.WIDTH($bits(speed_pair_t)),
		.DEPTH(OQ_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (oq_full),
		.wdata (res_in),
		.pop   (pop),
		.empty (empty),
		.rdata (res_out)
	);

	assign left_wheel  = res_out.left;
	assign right_wheel = res_out.right;

endmodule

// ===== rtl/tlcd_checker.sv =====
// ----------------------------------------------------------------------------
// tlcd_checker
// port level checks of the teleop line command decoder
// ----------------------------------------------------------------------------
module tlcd_checker import tlcd_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    push,
	input logic                    full,
	input logic [7:0]              rx_byte,
	input logic                    empty,
	input logic                    pop,
	input logic signed [SPD_W-1:0] left_wheel,
	input logic signed [SPD_W-1:0] right_wheel
);

	// queues are cleared while reset is held
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("queues not cleared in reset");

	// only a line end can fill the command queue
	a_full_on_eol: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && (rx_byte != 8'd10) && (rx_byte != 8'd13)) |=> !full)
		else $error("full rose without a line end transaction");

	// a waiting result holds until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(left_wheel) && $stable(right_wheel)))
		else $error("waiting result changed or vanished");

endmodule

bind teleop_line_command_decoder_unit tlcd_checker u_tlcd_checker (.*);
